// ===== hdl/srp_pkg.sv =====
package srp_pkg;

  localparam int unsigned TileW = 13;
  localparam int unsigned PosW  = 15;

  // Position counters stop here instead of wrapping.
  localparam logic [PosW-1:0] PosSat = {PosW{1'b1}};

  // Packing state carried from one tile to the next.
  typedef struct packed {
    logic [PosW-1:0]  cur_width;
    logic [PosW-1:0]  cur_height;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [PosW-1:0]  shelf_start_x;
    logic [TileW-1:0] shelf_height;
  } srp_state_t;

  // One placement word.
  typedef struct packed {
    logic [PosW-1:0] x_offset;
    logic [PosW-1:0] y_offset;
    logic [PosW-1:0] atlas_width;
    logic [PosW-1:0] atlas_height;
    logic            grew;
    logic            growth_refused;
    logic            fits_inside;
  } srp_result_t;

  // Clamp a 16-bit sum of two counters to the 15-bit saturation value.
  function automatic logic [PosW-1:0] sat_pos(input logic [PosW:0] s);
    logic [PosW-1:0] r;
    r = s[PosW] ? PosSat : s[PosW-1:0];
    return r;
  endfunction

endpackage

// ===== hdl/srp_tile_if.sv =====
interface srp_tile_if;
  import srp_pkg::*;

  logic             valid;
  logic             ready;
  logic [TileW-1:0] tile_width;
  logic [TileW-1:0] tile_height;

  modport source (output valid, output tile_width, output tile_height, input ready);
  modport sink   (input valid, input tile_width, input tile_height, output ready);

endinterface

// ===== hdl/srp_place_if.sv =====
interface srp_place_if;
  import srp_pkg::*;

  logic            valid;
  logic            ready;
  logic [PosW-1:0] x_offset;
  logic [PosW-1:0] y_offset;
  logic [PosW-1:0] atlas_width;
  logic [PosW-1:0] atlas_height;
  logic            grew;
  logic            growth_refused;
  logic            fits_inside;

  modport source (
    output valid, output x_offset, output y_offset, output atlas_width,
    output atlas_height, output grew, output growth_refused, output fits_inside,
    input ready
  );
  modport sink (
    input valid, input x_offset, input y_offset, input atlas_width,
    input atlas_height, input grew, input growth_refused, input fits_inside,
    output ready
  );

endinterface

// ===== hdl/shelf_rect_packer.sv =====
// Shelf packer for tiles in a growing texture atlas.
// tile_i takes one word per tile (tile_width, tile_height); place_o returns
// one word per tile: its x/y position, the atlas size after placement, and
// the grew / growth_refused / fits_inside flags. Both channels move a word
// at a rising edge where valid and ready are both high.
// A tile accepted into the input register is placed by one pass of logic
// against the packing state and shows on place_o from the result register.
// Unless place_o stalls, one tile per cycle; state is updated in the same
// cycle that the result register loads, so each tile sees the last one.
// tile_i.ready stays high while the result register is empty or being
// taken; when the receiver stalls, one word waits in the result register and
// one in the input register, then tile_i.ready drops until place_o drains.
// Reset (rst_ni low, asynchronous) empties both registers and restores an
// INIT_SIZE square atlas with the cursor at the origin. Growth is capped at
// MAX_SIZE per side; tile sides above TILE_MAX count as TILE_MAX.
module shelf_rect_packer import srp_pkg::*; #(
  parameter int unsigned INIT_SIZE = 512,
  parameter int unsigned MAX_SIZE  = 16384,
  parameter int unsigned TILE_MAX  = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srp_tile_if.sink    tile_i,
  srp_place_if.source place_o
);

  localparam logic [PosW-1:0] InitSize = PosW'(INIT_SIZE);

  logic             in_valid_q;
  logic [TileW-1:0] in_width_q;
  logic [TileW-1:0] in_height_q;
  logic             out_valid_q;
  srp_result_t      out_q;
  srp_state_t       state_q;
  srp_state_t       state_d;
  srp_result_t      result;
  logic             advance;
  logic             in_take;

  // Placement step fires when the input register holds a word and the result register can take one.
  assign advance = in_valid_q && (!out_valid_q || place_o.ready);
  assign tile_i.ready = !in_valid_q || advance;
  assign in_take = tile_i.valid && tile_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (tile_i.ready) begin
      in_valid_q <= tile_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_width_q  <= tile_i.tile_width;
      in_height_q <= tile_i.tile_height;
    end
  end

  srp_calc #(
    .MAX_SIZE (MAX_SIZE),
    .TILE_MAX (TILE_MAX)
  ) u_calc (
    .tile_width_i  (in_width_q),
    .tile_height_i (in_height_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .result_o      (result)
  );

  // Packing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cur_width     <= InitSize;
      state_q.cur_height    <= InitSize;
      state_q.pos_x         <= '0;
      state_q.pos_y         <= '0;
      state_q.shelf_start_x <= '0;
      state_q.shelf_height  <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || place_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign place_o.valid          = out_valid_q;
  assign place_o.x_offset       = out_q.x_offset;
  assign place_o.y_offset       = out_q.y_offset;
  assign place_o.atlas_width    = out_q.atlas_width;
  assign place_o.atlas_height   = out_q.atlas_height;
  assign place_o.grew           = out_q.grew;
  assign place_o.growth_refused = out_q.growth_refused;
  assign place_o.fits_inside    = out_q.fits_inside;

`ifndef NO_ASSERTIONS
  // Packing state moves only when a tile is placed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("packing state changed without a placement");

  // The atlas never shrinks.
  a_atlas_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (state_q.cur_width >= $past(state_q.cur_width)) &&
                (state_q.cur_height >= $past(state_q.cur_height)))
    else $error("atlas size decreased");

  // A word in the input register is never dropped while blocked.
  a_in_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(in_width_q) &&
                                 $stable(in_height_q))
    else $error("pending tile lost");

  // A tile may grow the atlas or be refused growth, never both.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.grew && out_q.growth_refused))
    else $error("grew and growth_refused both set");
`endif

endmodule

// ===== hdl/srp_calc.sv =====
module srp_calc import srp_pkg::*; #(
  parameter int unsigned MAX_SIZE = 16384,
  parameter int unsigned TILE_MAX = 4096
) (
  input  logic [TileW-1:0] tile_width_i,
  input  logic [TileW-1:0] tile_height_i,
  input  srp_state_t       state_i,
  output srp_state_t       state_o,
  output srp_result_t      result_o
);

  localparam logic [TileW-1:0] TileMax = TileW'(TILE_MAX);
  localparam logic [PosW:0]    MaxSize = (PosW + 1)'(MAX_SIZE);

  logic [TileW-1:0] w;
  logic [TileW-1:0] h;
  srp_state_t       st;
  logic             grew;
  logic             refused;
  logic             fits;

  // Oversized tiles are treated as the largest allowed tile.
  assign w = (tile_width_i  > TileMax) ? TileMax : tile_width_i;
  assign h = (tile_height_i > TileMax) ? TileMax : tile_height_i;

  // Shelf break, then at most one doubling, then placement.
  always_comb begin
    st      = state_i;
    grew    = 1'b0;
    refused = 1'b0;

    // Row full: next shelf below the tallest tile of this row.
    if ({1'b0, st.pos_x} + (PosW + 1)'(w) > {1'b0, st.cur_width}) begin
      st.pos_x        = st.shelf_start_x;
      st.pos_y        = sat_pos({1'b0, st.pos_y} + (PosW + 1)'(st.shelf_height));
      st.shelf_height = '0;
    end

    // Too tall: double the shorter side, or the width when square.
    if ({1'b0, st.pos_y} + (PosW + 1)'(h) > {1'b0, st.cur_height}) begin
      if (st.cur_height < st.cur_width) begin
        if ({st.cur_height, 1'b0} > MaxSize) begin
          refused = 1'b1;
        end else begin
          st.pos_y         = st.cur_height;
          st.cur_height    = {st.cur_height[PosW-2:0], 1'b0};
          st.shelf_start_x = '0;
          st.pos_x         = '0;
          st.shelf_height  = '0;
          grew             = 1'b1;
        end
      end else begin
        if ({st.cur_width, 1'b0} > MaxSize) begin
          refused = 1'b1;
        end else begin
          st.shelf_start_x = st.cur_width;
          st.pos_x         = st.cur_width;
          st.pos_y         = '0;
          st.cur_width     = {st.cur_width[PosW-2:0], 1'b0};
          st.shelf_height  = '0;
          grew             = 1'b1;
        end
      end
    end

    fits = ({1'b0, st.pos_x} + (PosW + 1)'(w) <= {1'b0, st.cur_width}) &&
           ({1'b0, st.pos_y} + (PosW + 1)'(h) <= {1'b0, st.cur_height});

    result_o.x_offset       = st.pos_x;
    result_o.y_offset       = st.pos_y;
    result_o.atlas_width    = st.cur_width;
    result_o.atlas_height   = st.cur_height;
    result_o.grew           = grew;
    result_o.growth_refused = refused;
    result_o.fits_inside    = fits;

    // Advance past the tile and track the tallest tile of the row.
    st.pos_x = sat_pos({1'b0, st.pos_x} + (PosW + 1)'(w));
    if (h > st.shelf_height) begin
      st.shelf_height = h;
    end

    state_o = st;
  end

endmodule

// ===== tb/shelf_rect_packer_tb.sv =====
module shelf_rect_packer_tb import srp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned InitSize = 512;
  localparam int unsigned MaxSize  = 16384;
  localparam int unsigned TileMax  = 4096;
  localparam realtime     HalfPeriod = 4ns;

  // One directed tile; want only counts where typed is set.
  typedef struct {
    logic [TileW-1:0] w;
    logic [TileW-1:0] h;
    bit               typed;
    srp_result_t      want;
  } tile_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  srp_tile_if  tile_bus ();
  srp_place_if place_bus ();

  shelf_rect_packer #(
    .INIT_SIZE (InitSize),
    .MAX_SIZE  (MaxSize),
    .TILE_MAX  (TileMax)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tile_i  (tile_bus),
    .place_o (place_bus)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Shadow packing state and placements still owed by the block.
  srp_state_t  atlas_q;
  srp_result_t placements_due [$];

  int unsigned tiles_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned growths       = 0;
  int unsigned refusals      = 0;
  int unsigned fails         = 0;
  bit          calm          = 1'b0;

  // Opening tiles: reset state, side extremes, oversized and zero tiles,
  // a growth that still leaves the tile hanging out, alternating bit patterns.
  tile_row_t opening [11] = '{
    '{13'd0,    13'd0,    1'b1,
      '{15'd0,   15'd0,   15'd512,  15'd512,  1'b0, 1'b0, 1'b1}},
    '{13'd8191, 13'd8191, 1'b1,
      '{15'd512, 15'd0,   15'd1024, 15'd512,  1'b1, 1'b0, 1'b0}},
    '{13'd1,    13'd1,    1'b1,
      '{15'd0,   15'd512, 15'd1024, 15'd1024, 1'b1, 1'b0, 1'b1}},
    '{13'd4096, 13'd0,    1'b0, '0},
    '{13'd0,    13'd4096, 1'b0, '0},
    '{13'd4097, 13'd4097, 1'b0, '0},
    '{13'd4095, 13'd1,    1'b0, '0},
    '{13'd0,    13'd0,    1'b0, '0},
    '{13'h0AAA, 13'h1555, 1'b0, '0},
    '{13'h1555, 13'h0AAA, 1'b0, '0},
    '{13'd1,    13'd1,    1'b0, '0}
  };

  function automatic int unsigned clip_pos(input int unsigned s);
    return (s > int'(PosSat)) ? int'(PosSat) : s;
  endfunction

  // Shelf placement of one tile against the shadow state.
  function automatic srp_result_t place_tile(input logic [TileW-1:0] w_raw,
                                             input logic [TileW-1:0] h_raw);
    int unsigned w, h, px, py, cw, ch, sx, sh;
    srp_result_t r;
    w  = (w_raw > TileMax) ? TileMax : w_raw;
    h  = (h_raw > TileMax) ? TileMax : h_raw;
    cw = atlas_q.cur_width;
    ch = atlas_q.cur_height;
    px = atlas_q.pos_x;
    py = atlas_q.pos_y;
    sx = atlas_q.shelf_start_x;
    sh = atlas_q.shelf_height;
    r  = '0;
    // row full: next shelf below the tallest tile of this row
    if (px + w > cw) begin
      px = sx;
      py = clip_pos(py + sh);
      sh = 0;
    end
    // too tall: double once, height first when the atlas is wide
    if (py + h > ch) begin
      if (ch < cw) begin
        if (2 * ch > MaxSize) begin
          r.growth_refused = 1'b1;
        end else begin
          py = ch;
          ch = 2 * ch;
          sx = 0;
          px = 0;
          sh = 0;
          r.grew = 1'b1;
        end
      end else begin
        if (2 * cw > MaxSize) begin
          r.growth_refused = 1'b1;
        end else begin
          sx = cw;
          px = cw;
          py = 0;
          cw = 2 * cw;
          sh = 0;
          r.grew = 1'b1;
        end
      end
    end
    r.x_offset     = PosW'(px);
    r.y_offset     = PosW'(py);
    r.atlas_width  = PosW'(cw);
    r.atlas_height = PosW'(ch);
    r.fits_inside  = (px + w <= cw) && (py + h <= ch);
    px = clip_pos(px + w);
    if (h > sh) sh = h;
    atlas_q.cur_width     = PosW'(cw);
    atlas_q.cur_height    = PosW'(ch);
    atlas_q.pos_x         = PosW'(px);
    atlas_q.pos_y         = PosW'(py);
    atlas_q.shelf_start_x = PosW'(sx);
    atlas_q.shelf_height  = TileW'(sh);
    return r;
  endfunction

  // Side length mix: mostly small tiles early on, large and oversized later.
  function automatic logic [TileW-1:0] roll_side(input bit coarse);
    int unsigned r;
    r = $urandom_range(0, 999);
    if (!coarse) begin
      if (r < 30) return '0;
      if (r < 33) return TileW'($urandom_range(0, (1 << TileW) - 1));
      if (r < 620) return TileW'($urandom_range(1, 31));
      if (r < 880) return TileW'($urandom_range(32, 255));
      return TileW'($urandom_range(256, 700));
    end
    if (r < 200) return TileW'($urandom_range(0, 63));
    if (r < 300) return TileW'($urandom_range(256, 1023));
    if (r < 800) return TileW'($urandom_range(1024, TileMax));
    return TileW'($urandom_range(TileMax + 1, (1 << TileW) - 1));
  endfunction

  // Send one tile word, with random gaps, and book its placement.
  task automatic drive_tile(input logic [TileW-1:0] w, input logic [TileW-1:0] h,
                            input bit typed, input srp_result_t want);
    srp_result_t pred;
    calm = (tiles_sent >= 500) && (tiles_sent < 800);
    while (!calm && ($urandom_range(0, 99) < 36)) begin
      tile_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    tile_bus.valid       <= 1'b1;
    tile_bus.tile_width  <= w;
    tile_bus.tile_height <= h;
    @(posedge clk_i);
    while (!tile_bus.ready) @(posedge clk_i);
    pred = place_tile(w, h);
    placements_due.push_back(typed ? want : pred);
    tiles_sent++;
    if (pred.grew) growths++;
    if (pred.growth_refused) refusals++;
  endtask

  function automatic void check_field(input string name, input logic [PosW-1:0] want,
                                      input logic [PosW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Tile source: reset, directed opening, small random tiles, a run of
  // maximum tiles until growth is refused, then large random tiles.
  initial begin : tile_source
    int unsigned tries;
    int unsigned seen;
    atlas_q            = '0;
    atlas_q.cur_width  = PosW'(InitSize);
    atlas_q.cur_height = PosW'(InitSize);
    tile_bus.valid       <= 1'b0;
    tile_bus.tile_width  <= '0;
    tile_bus.tile_height <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) begin
      drive_tile(opening[i].w, opening[i].h, opening[i].typed, opening[i].want);
    end
    repeat (1600) drive_tile(roll_side(1'b0), roll_side(1'b0), 1'b0, '0);
    // atlas fills up to MAX_SIZE on both sides, then refuses to grow
    tries = 0;
    seen  = refusals;
    while ((refusals == seen) && (tries < 64)) begin
      drive_tile(TileW'(TileMax), TileW'(TileMax), 1'b0, '0);
      tries++;
    end
    repeat (260) drive_tile(roll_side(1'b1), roll_side(1'b1), 1'b0, '0);
    tile_bus.valid <= 1'b0;

    while (placements_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Placed %0d tiles and checked %0d words; %0d growths, %0d refused.",
             tiles_sent, words_checked, growths, refusals);
    $display("Final atlas %0d x %0d, cursor at y = %0d.",
             atlas_q.cur_width, atlas_q.cur_height, atlas_q.pos_y);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Placement sink: random stalls, compare each word with the oldest booking.
  initial begin : place_sink
    srp_result_t want;
    place_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (place_bus.valid && place_bus.ready) begin
        if (placements_due.size() == 0) begin
          $error("placement word with no tile outstanding");
          fails++;
        end else begin
          want = placements_due.pop_front();
          check_field("x_offset", want.x_offset, place_bus.x_offset);
          check_field("y_offset", want.y_offset, place_bus.y_offset);
          check_field("atlas_width", want.atlas_width, place_bus.atlas_width);
          check_field("atlas_height", want.atlas_height, place_bus.atlas_height);
          check_field("grew", PosW'(want.grew), PosW'(place_bus.grew));
          check_field("growth_refused", PosW'(want.growth_refused),
                      PosW'(place_bus.growth_refused));
          check_field("fits_inside", PosW'(want.fits_inside),
                      PosW'(place_bus.fits_inside));
          words_checked++;
        end
      end
      place_bus.ready <= calm || ($urandom_range(0, 99) >= 36);
    end
  end

  // Watchdog.
  initial begin : watchdog
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
